// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/dwev_pkg.sv =====
package dwev_pkg;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_BAD_FORMAT      = 3'd1,
    ST_BAD_APPLICATION = 3'd2,
    ST_INDIRECT        = 3'd3,
    ST_OMIT            = 3'd4
  } status_t;

  localparam logic [3:0] FMT_ABSPTR = 4'h0;
  localparam logic [3:0] FMT_ULEB   = 4'h1;
  localparam logic [3:0] FMT_UDATA2 = 4'h2;
  localparam logic [3:0] FMT_UDATA4 = 4'h3;
  localparam logic [3:0] FMT_UDATA8 = 4'h4;
  localparam logic [3:0] FMT_SLEB   = 4'h9;
  localparam logic [3:0] FMT_SDATA2 = 4'hA;
  localparam logic [3:0] FMT_SDATA4 = 4'hB;
  localparam logic [3:0] FMT_SDATA8 = 4'hC;

  localparam logic [2:0] APP_ABS   = 3'd0;
  localparam logic [2:0] APP_PCREL = 3'd1;

  localparam logic [7:0] ENC_OMIT  = 8'hFF;
  localparam logic [6:0] SHIFT_CAP = 7'd70;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // Register indexes on the configuration port.
  localparam logic REG_ENCODING = 1'b0;
  localparam logic REG_BASE     = 1'b1;

  typedef struct packed {
    logic [63:0] acc;
    logic [6:0]  bit_shift;
    logic [7:0]  bytes_taken;
    logic [63:0] stream_addr;
    logic [63:0] vstart;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] acc;
    logic [63:0] vstart;
    logic        pcrel;
    status_t     status;
    logic [7:0]  count;
  } step_res_t;

  // Byte size of a fixed format, zero for LEB and unsupported formats.
  function automatic logic [3:0] fixed_size(logic [3:0] fmt);
    logic [3:0] n;
    case (fmt)
      FMT_ABSPTR, FMT_UDATA8, FMT_SDATA8: n = 4'd8;
      FMT_UDATA2, FMT_SDATA2:             n = 4'd2;
      FMT_UDATA4, FMT_SDATA4:             n = 4'd4;
      default:                            n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic status_t enc_status(logic [7:0] enc);
    status_t st;
    logic    fmt_ok;
    fmt_ok = (enc[3:0] == FMT_ULEB) || (enc[3:0] == FMT_SLEB) ||
             (fixed_size(enc[3:0]) != 4'd0);
    if (enc == ENC_OMIT) begin
      st = ST_OMIT;
    end else if (!fmt_ok) begin
      st = ST_BAD_FORMAT;
    end else if (enc[6:4] != APP_ABS && enc[6:4] != APP_PCREL) begin
      st = ST_BAD_APPLICATION;
    end else if (enc[7]) begin
      st = ST_INDIRECT;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

// ===== rtl/core/dwev_step.sv =====
module dwev_step (
  input  dwev_pkg::dec_state_t cur,
  input  logic [7:0]           encoding,
  input  logic [63:0]          base_address,
  input  logic [7:0]           data_byte,
  input  logic                 restart,
  output dwev_pkg::dec_state_t nxt,
  output dwev_pkg::step_res_t  res
);
  import dwev_pkg::*;

  logic [63:0] acc;
  logic [6:0]  bs;
  logic [7:0]  bt;
  logic [7:0]  bt_inc;
  logic [63:0] sa;
  logic [63:0] vstart;
  logic [3:0]  fmt;
  logic [3:0]  n;
  logic [7:0]  bs_sum;
  logic [6:0]  bs_new;
  logic        done;
  status_t     st;

  always_comb begin
    acc    = restart ? 64'd0 : cur.acc;
    bs     = restart ? 7'd0 : cur.bit_shift;
    bt     = restart ? 8'd0 : cur.bytes_taken;
    sa     = restart ? base_address : cur.stream_addr;
    st     = enc_status(encoding);
    fmt    = encoding[3:0];
    n      = fixed_size(fmt);
    bt_inc = (bt < COUNT_MAX) ? bt + 8'd1 : bt;
    bs_sum = {1'b0, bs} + 8'd7;
    bs_new = (bs_sum > {1'b0, SHIFT_CAP}) ? SHIFT_CAP : bs_sum[6:0];
    vstart = (bt == 8'd0) ? sa : cur.vstart;
    done   = 1'b0;

    nxt.stream_addr = sa + 64'd1;
    nxt.vstart      = cur.vstart;
    nxt.acc         = 64'd0;
    nxt.bit_shift   = 7'd0;
    nxt.bytes_taken = 8'd0;

    res.valid  = 1'b0;
    res.acc    = 64'd0;
    res.vstart = vstart;
    // error results carry a zero value, so no address is added to them
    res.pcrel  = (st == ST_OK) && (encoding[6:4] == APP_PCREL);
    res.status = st;
    res.count  = 8'd0;

    if (st != ST_OK) begin
      res.valid = 1'b1;
    end else begin
      nxt.vstart = vstart;
      if (n != 4'd0) begin
        if (bt < 8'd8) begin
          acc = acc | ({56'd0, data_byte} << {bt[2:0], 3'b000});
        end
        done = (bt_inc >= {4'd0, n});
        if (done && fmt[3]) begin
          if (n == 4'd2 && acc[15]) begin
            acc[63:16] = '1;
          end
          if (n == 4'd4 && acc[31]) begin
            acc[63:32] = '1;
          end
        end
      end else begin
        if (bs < 7'd64) begin
          acc = acc | ({57'd0, data_byte[6:0]} << bs[5:0]);
        end
        done = !data_byte[7];
        if (done && fmt == FMT_SLEB && data_byte[6] && bs_new < 7'd64) begin
          acc = acc | ({64{1'b1}} << bs_new[5:0]);
        end
      end
      if (done) begin
        res.valid = 1'b1;
        res.acc   = acc;
        res.count = bt_inc;
      end else begin
        // hold the partial value
        nxt.acc         = acc;
        nxt.bit_shift   = (n != 4'd0) ? bs : bs_new;
        nxt.bytes_taken = bt_inc;
      end
    end
  end

endmodule

// ===== rtl/core/dwarf_encoded_value_decoder.sv =====
// Decodes one stream byte per cycle while in_stall is low; a new byte is taken every cycle that in_stall is low.
// A value's result is registered in the decode register when its last byte is
// taken, then goes through the pc-relative add into the output register.
// Throughput: one byte per cycle while not stalled, set by the single decode pass per byte.
// Reset (rst_n low, synchronous): encoding 0xFF, base 0, partial value and
// stream address cleared, pipeline empty.
`include "assert_macros.svh"

module dwarf_encoded_value_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_restart,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [63:0]           out_value,
  output logic [2:0]            out_status,
  output logic [7:0]            out_byte_count,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);
  import dwev_pkg::*;

  logic [7:0]  encoding_r;
  logic [63:0] base_r;
  dec_state_t  state_r;
  dec_state_t  state_nxt;
  step_res_t   step_res;
  step_res_t   s1_r;
  logic        s1_valid_r;
  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic [2:0]  out_status_r;
  logic [7:0]  out_count_r;
  logic        cfg_wr;
  logic        s2_load;
  logic        in_fire;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign s2_load = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_load;
  assign in_fire = in_valid && !in_stall;

  always_comb begin
    case (paddr[3])
      REG_ENCODING: prdata = {56'd0, encoding_r};
      REG_BASE:     prdata = base_r;
      default:      prdata = 64'd0;
    endcase
  end

  dwev_step u_step (
    .cur          (state_r),
    .encoding     (encoding_r),
    .base_address (base_r),
    .data_byte    (in_data_byte),
    .restart      (in_restart),
    .nxt          (state_nxt),
    .res          (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encoding_r <= ENC_OMIT;
      base_r     <= 64'd0;
      state_r    <= '0;
    end else begin
      if (cfg_wr && paddr[3] == REG_BASE) begin
        base_r <= pwdata;
      end
      if (cfg_wr && paddr[3] == REG_ENCODING) begin
        encoding_r <= pwdata[7:0];
        // drop any partial value
        state_r.acc         <= 64'd0;
        state_r.bit_shift   <= 7'd0;
        state_r.bytes_taken <= 8'd0;
      end else if (in_fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= step_res.valid;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= step_res;
    end
    if (s2_load && s1_valid_r) begin
      out_value_r  <= s1_r.acc + (s1_r.pcrel ? s1_r.vstart : 64'd0);
      out_status_r <= s1_r.status;
      out_count_r  <= s1_r.count;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_status     = out_status_r;
  assign out_byte_count = out_count_r;

  `ASSERT_IMPL(a_err_zero, out_valid && out_status != ST_OK,
               out_value == 64'd0 && out_byte_count == 8'd0, "error result not zeroed")
  `ASSERT_IMPL(a_ok_count, out_valid && out_status == ST_OK,
               out_byte_count != 8'd0, "ok result with no bytes")
  `ASSERT_IMPL(a_stall_full, in_stall, s1_valid_r && out_valid_r,
               "input stalled with pipeline not full")
  `ASSERT_CLK(a_s1_drain, s1_valid_r && s2_load && !in_fire |=> !s1_valid_r,
              "decode stage not drained")

endmodule
